// ===== rtl/core/pump_runtime_window_log_unit_assert.svh =====
// assertion macros for the pump runtime window log unit
`ifndef PUMP_RUNTIME_WINDOW_LOG_UNIT_ASSERT_SVH
`define PUMP_RUNTIME_WINDOW_LOG_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PRWL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PRWL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/prwl_pkg.sv =====
// shared types and constants of the pump runtime window log unit
package prwl_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned LOG_ENTRIES_DEF = 128;
	localparam int unsigned CFG_IDX_W       = 2;

	localparam logic [DATA_W-1:0] SHORT_WINDOW_RST = 32'd86400000;
	localparam logic [DATA_W-1:0] LONG_WINDOW_RST  = 32'd604800000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} prwl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic write;
		logic scan_start;
		logic scan_step;
		logic result_load;
	} prwl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} prwl_stat_t;

endpackage

// ===== rtl/core/prwl_ctrl.sv =====
// controller state machine: accept, log write, scan, drain, result hand-off
module prwl_ctrl
	import prwl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  prwl_stat_t stat,
	output prwl_cmd_t  cmd
);

	prwl_state_t state_q;
	prwl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd             = '0;
		in_stall        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_WRITE: begin
				cmd.write      = 1'b1;
				cmd.scan_start = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_DONE: begin
				cmd.result_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/prwl_dp.sv =====
// datapath: sample registers, two ring logs, scan pipeline, window sums, result register
module prwl_dp
	import prwl_pkg::*;
#(
	parameter int unsigned LOG_ENTRIES = LOG_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prwl_cmd_t         cmd,
	output prwl_stat_t        stat,
	input  logic [DATA_W-1:0] short_window,
	input  logic [DATA_W-1:0] long_window,
	input  logic [DATA_W-1:0] now_ms,
	input  logic              pump_one_on,
	input  logic              pump_two_on,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] pump_one_short_ms,
	output logic [DATA_W-1:0] pump_one_long_ms,
	output logic [DATA_W-1:0] pump_two_short_ms,
	output logic [DATA_W-1:0] pump_two_long_ms
);

	localparam int unsigned AW = $clog2(LOG_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(LOG_ENTRIES - 1);
	localparam logic [AW:0]   FULL_CNT = (AW + 1)'(LOG_ENTRIES);

	// sample registers
	logic [DATA_W-1:0] now_q;
	logic [DATA_W-1:0] prev_q;
	logic              on1_q;
	logic              on2_q;

	// ring log write pointers and fill counts
	logic [AW-1:0] slot1_q;
	logic [AW-1:0] slot2_q;
	logic [AW:0]   fill1_q;
	logic [AW:0]   fill2_q;

	// log memories, entry = {start, duration}
	logic [2*DATA_W-1:0] mem1 [LOG_ENTRIES];
	logic [2*DATA_W-1:0] mem2 [LOG_ENTRIES];

	// scan pipeline
	logic [AW-1:0]       idx_q;
	logic                vld_s1;
	logic                ok1_s1;
	logic                ok2_s1;
	logic [2*DATA_W-1:0] rd1_s1;
	logic [2*DATA_W-1:0] rd2_s1;
	logic                vld_s2;
	logic                sh1_s2;
	logic                lg1_s2;
	logic                sh2_s2;
	logic                lg2_s2;
	logic [DATA_W-1:0]   dur1_s2;
	logic [DATA_W-1:0]   dur2_s2;

	// window sums and result register
	logic [DATA_W-1:0] sum1_short_q;
	logic [DATA_W-1:0] sum1_long_q;
	logic [DATA_W-1:0] sum2_short_q;
	logic [DATA_W-1:0] sum2_long_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] res1_short_q;
	logic [DATA_W-1:0] res1_long_q;
	logic [DATA_W-1:0] res2_short_q;
	logic [DATA_W-1:0] res2_long_q;

	logic [DATA_W-1:0] dur_new;
	logic [DATA_W-1:0] age1;
	logic [DATA_W-1:0] age2;

	assign dur_new = now_q - prev_q;
	assign age1    = now_q - rd1_s1[2*DATA_W-1:DATA_W];
	assign age2    = now_q - rd2_s1[2*DATA_W-1:DATA_W];

	// latch sample on request, advance previous time after the log write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			prev_q <= '0;
			on1_q  <= 1'b0;
			on2_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				now_q <= now_ms;
				on1_q <= pump_one_on;
				on2_q <= pump_two_on;
			end
			if (cmd.write) prev_q <= now_q;
		end
	end

	// slot and fill tracking per pump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot1_q <= '0;
			slot2_q <= '0;
			fill1_q <= '0;
			fill2_q <= '0;
		end else if (cmd.write) begin
			if (on1_q) begin
				slot1_q <= (slot1_q == LAST_IDX) ? '0 : slot1_q + 1'b1;
				if (fill1_q != FULL_CNT) fill1_q <= fill1_q + 1'b1;
			end
			if (on2_q) begin
				slot2_q <= (slot2_q == LAST_IDX) ? '0 : slot2_q + 1'b1;
				if (fill2_q != FULL_CNT) fill2_q <= fill2_q + 1'b1;
			end
		end
	end

	// log memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.write && on1_q) mem1[slot1_q] <= {now_q, dur_new};
		if (cmd.write && on2_q) mem2[slot2_q] <= {now_q, dur_new};
		rd1_s1 <= mem1[idx_q];
		rd2_s1 <= mem2[idx_q];
	end

	// scan index and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			ok1_s1 <= 1'b0;
			ok2_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
			vld_s1 <= cmd.scan_step;
			ok1_s1 <= ({1'b0, idx_q} < fill1_q);
			ok2_s1 <= ({1'b0, idx_q} < fill2_q);
			vld_s2 <= vld_s1;
		end
	end

	// window compare stage
	always_ff @(posedge clk) begin
		sh1_s2  <= ok1_s1 && (rd1_s1[2*DATA_W-1:DATA_W] != '0) && (age1 <= short_window);
		lg1_s2  <= ok1_s1 && (rd1_s1[2*DATA_W-1:DATA_W] != '0) && (age1 <= long_window);
		sh2_s2  <= ok2_s1 && (rd2_s1[2*DATA_W-1:DATA_W] != '0) && (age2 <= short_window);
		lg2_s2  <= ok2_s1 && (rd2_s1[2*DATA_W-1:DATA_W] != '0) && (age2 <= long_window);
		dur1_s2 <= rd1_s1[DATA_W-1:0];
		dur2_s2 <= rd2_s1[DATA_W-1:0];
	end

	// wrapping window sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum1_short_q <= '0;
			sum1_long_q  <= '0;
			sum2_short_q <= '0;
			sum2_long_q  <= '0;
		end else if (cmd.scan_start) begin
			sum1_short_q <= '0;
			sum1_long_q  <= '0;
			sum2_short_q <= '0;
			sum2_long_q  <= '0;
		end else if (vld_s2) begin
			if (sh1_s2) sum1_short_q <= sum1_short_q + dur1_s2;
			if (lg1_s2) sum1_long_q  <= sum1_long_q + dur1_s2;
			if (sh2_s2) sum2_short_q <= sum2_short_q + dur2_s2;
			if (lg2_s2) sum2_long_q  <= sum2_long_q + dur2_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			res1_short_q <= sum1_short_q;
			res1_long_q  <= sum1_long_q;
			res2_short_q <= sum2_short_q;
			res2_long_q  <= sum2_long_q;
		end
	end

	// status back to the controller
	assign stat.scan_last = (idx_q == LAST_IDX);
	assign stat.pipe_busy = vld_s1 | vld_s2;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid         = out_valid_q;
	assign pump_one_short_ms = res1_short_q;
	assign pump_one_long_ms  = res1_long_q;
	assign pump_two_short_ms = res2_short_q;
	assign pump_two_long_ms  = res2_long_q;

endmodule

// ===== rtl/core/pump_runtime_window_log_unit.sv =====
// top level of the pump runtime window log unit
//
//  channel | direction | handshake           | payload
//  in      | request   | in_valid/in_stall   | now_ms, pump_one_on, pump_two_on
//  out     | result    | out_valid/out_stall | pump_*_short_ms, pump_*_long_ms
//  cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  a request runs from accept to the next accept through a write state, a scan step per
//  log entry, a drain of the scan pipeline and the result load in the done state
//  after reset both logs count as empty by their fill counts, no clearing pass
//  a new request is accepted while the previous result still sits in the output
//  register; a stalled result holds the controller in its done state, with the
//  finished sums kept in the datapath until the output register frees up
`include "pump_runtime_window_log_unit_assert.svh"
module pump_runtime_window_log_unit
	import prwl_pkg::*;
#(
	parameter int unsigned LOG_ENTRIES = LOG_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DATA_W-1:0]    now_ms,
	input  logic                 pump_one_on,
	input  logic                 pump_two_on,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    pump_one_short_ms,
	output logic [DATA_W-1:0]    pump_one_long_ms,
	output logic [DATA_W-1:0]    pump_two_short_ms,
	output logic [DATA_W-1:0]    pump_two_long_ms,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	logic [DATA_W-1:0] short_window_q;
	logic [DATA_W-1:0] long_window_q;
	prwl_cmd_t         cmd;
	prwl_stat_t        stat;

	assign cfg_ready = 1'b1;

	// window registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= SHORT_WINDOW_RST;
			long_window_q  <= LONG_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHORT_WINDOW: short_window_q <= cfg_data;
				CFG_LONG_WINDOW:  long_window_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	prwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	prwl_dp #(
		.LOG_ENTRIES (LOG_ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.short_window      (short_window_q),
		.long_window       (long_window_q),
		.now_ms            (now_ms),
		.pump_one_on       (pump_one_on),
		.pump_two_on       (pump_two_on),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.pump_one_short_ms (pump_one_short_ms),
		.pump_one_long_ms  (pump_one_long_ms),
		.pump_two_short_ms (pump_two_short_ms),
		.pump_two_long_ms  (pump_two_long_ms)
	);

	// one request at a time: stall right after a request is taken
	`PRWL_ASSERT_NEXT(a_stall_after_req, in_valid && !in_stall, in_stall, "request overlap")
	// a result is never loaded over one that is still stalled
	`PRWL_ASSERT_NOW(a_no_overwrite, cmd.result_load, !out_valid || !out_stall, "result lost")
	// result valid only appears after a result load
	`PRWL_ASSERT_NOW(a_valid_source, $rose(out_valid), $past(cmd.result_load), "stray result")

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the pump runtime window log unit
`timescale 1ns / 100ps

module testbench;
	import prwl_pkg::*;

	localparam int LOG_DEPTH     = LOG_ENTRIES_DEF;
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 180;
	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int REPORT_CAP    = 100;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TWO   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_THREE = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] one_short;
		logic [DATA_W-1:0] one_long;
		logic [DATA_W-1:0] two_short;
		logic [DATA_W-1:0] two_long;
	} pump_sums_t;

	// mirror of both runtime logs and the window sums they produce
	class runtime_window_board;
		bit [DATA_W-1:0] short_window;
		bit [DATA_W-1:0] long_window;
		bit [DATA_W-1:0] last_time;
		bit [DATA_W-1:0] start_ms[2][LOG_DEPTH];
		bit [DATA_W-1:0] run_ms[2][LOG_DEPTH];
		int unsigned     next_slot[2];
		pump_sums_t      pending_sums[$];
		int unsigned     errors;
		int unsigned     checked;
		int unsigned     entries_written;

		function new();
			short_window = SHORT_WINDOW_RST;
			long_window  = LONG_WINDOW_RST;
		endfunction

		function void set_window(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
			case (index)
				CFG_SHORT_WINDOW: short_window = value;
				CFG_LONG_WINDOW:  long_window = value;
				default: ;
			endcase
		endfunction

		// append running pumps to their logs, then sum each log per window
		function void note_sample(logic [DATA_W-1:0] now, logic on_one, logic on_two);
			bit [1:0]        running;
			bit [DATA_W-1:0] age;
			bit [DATA_W-1:0] sum_short[2];
			bit [DATA_W-1:0] sum_long[2];
			pump_sums_t      sums;
			running = {on_two, on_one};
			for (int p = 0; p < 2; p++) begin
				sum_short[p] = '0;
				sum_long[p]  = '0;
				if (running[p]) begin
					start_ms[p][next_slot[p]] = now;
					run_ms[p][next_slot[p]]   = now - last_time;
					next_slot[p] = (next_slot[p] + 1) % LOG_DEPTH;
					entries_written++;
				end
				for (int i = 0; i < LOG_DEPTH; i++) begin
					// start of zero marks an empty entry
					if (start_ms[p][i] != '0) begin
						age = now - start_ms[p][i];
						if (age <= short_window)
							sum_short[p] += run_ms[p][i];
						if (age <= long_window)
							sum_long[p] += run_ms[p][i];
					end
				end
			end
			last_time = now;
			sums.one_short = sum_short[0];
			sums.one_long  = sum_long[0];
			sums.two_short = sum_short[1];
			sums.two_long  = sum_long[1];
			pending_sums.push_back(sums);
		endfunction

		function void compare_field(string field, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: %s expected %0d (0x%h) got %0d (0x%h)",
						$time, field, want, want, got, got);
			end
		endfunction

		function void check_sums(pump_sums_t got);
			pump_sums_t want;
			if (pending_sums.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, got %h", $time, got);
				return;
			end
			want = pending_sums.pop_front();
			checked++;
			compare_field("pump_one_short_ms", want.one_short, got.one_short);
			compare_field("pump_one_long_ms", want.one_long, got.one_long);
			compare_field("pump_two_short_ms", want.two_short, got.two_short);
			compare_field("pump_two_long_ms", want.two_long, got.two_long);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [DATA_W-1:0]    now_ms = '0;
	logic                 pump_one_on = 1'b0;
	logic                 pump_two_on = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [DATA_W-1:0]    pump_one_short_ms;
	logic [DATA_W-1:0]    pump_one_long_ms;
	logic [DATA_W-1:0]    pump_two_short_ms;
	logic [DATA_W-1:0]    pump_two_long_ms;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	runtime_window_board board = new();

	bit          sender_idle = 1'b1;
	bit          receiver_idle = 1'b1;
	int          stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned samples_sent = 0;
	int unsigned window_settings = 1;

	pump_runtime_window_log_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.now_ms            (now_ms),
		.pump_one_on       (pump_one_on),
		.pump_two_on       (pump_two_on),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.pump_one_short_ms (pump_one_short_ms),
		.pump_one_long_ms  (pump_one_long_ms),
		.pump_two_short_ms (pump_two_short_ms),
		.pump_two_long_ms  (pump_two_long_ms),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d results outstanding",
				board.pending_sums.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 300);
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (receiver_idle && $urandom_range(0, 99) < 20) begin
			stall_left = idle_length() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_sums({pump_one_short_ms, pump_one_long_ms,
				pump_two_short_ms, pump_two_long_ms});
	end

	// one sample request, with an optional gap before it
	task automatic send_sample(input logic [DATA_W-1:0] now, input logic on_one,
			input logic on_two);
		int gap;
		gap = (sender_idle && $urandom_range(0, 99) < 45) ? idle_length() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		now_ms      <= now;
		pump_one_on <= on_one;
		pump_two_on <= on_two;
		do @(posedge clk); while (in_stall);
		board.note_sample(now, on_one, on_two);
		samples_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_sums.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_window(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [DATA_W-1:0] now_t;
		logic [DATA_W-1:0] short_w;
		logic [DATA_W-1:0] long_w;
		int                step;
		int                r;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset windows: zero-time sample, first duration from zero, time wrap
		send_sample(32'h0000_0000, 1'b1, 1'b1);
		send_sample(32'd1000, 1'b1, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_sample(32'd5, 1'b0, 1'b0);
		send_sample(32'h0000_5000, 1'b1, 1'b1);

		// small windows, ages right on and just past each boundary
		wait_for_results();
		write_register(CFG_SHORT_WINDOW, 32'd100);
		write_register(CFG_LONG_WINDOW, 32'd1000);
		write_register(CFG_SPARE_TWO, 32'hFFFF_FFFF);
		write_register(CFG_SPARE_THREE, 32'h0000_0000);
		window_settings++;
		send_sample(32'h0010_0000, 1'b1, 1'b1);
		send_sample(32'h0010_0000 + 32'd100, 1'b0, 1'b0);
		send_sample(32'h0010_0000 + 32'd101, 1'b0, 1'b0);
		send_sample(32'h0010_0000 + 32'd1000, 1'b1, 1'b0);
		send_sample(32'h0010_0000 + 32'd1001, 1'b0, 1'b1);

		// zero short window, full long window, repeated and backward times
		wait_for_results();
		write_register(CFG_SHORT_WINDOW, 32'h0000_0000);
		write_register(CFG_LONG_WINDOW, 32'hFFFF_FFFF);
		window_settings++;
		send_sample(32'h8000_0000, 1'b1, 1'b1);
		send_sample(32'h8000_0000, 1'b1, 1'b0);
		send_sample(32'h7FFF_FFFF, 1'b0, 1'b1);

		// inverted extremes
		wait_for_results();
		write_register(CFG_SHORT_WINDOW, 32'hFFFF_FFFF);
		write_register(CFG_LONG_WINDOW, 32'h0000_0000);
		window_settings++;
		send_sample(32'hAAAA_AAAA, 1'b1, 1'b1);
		send_sample(32'h5555_5555, 1'b1, 1'b0);

		// random phases, each with its own window setting and time scale
		now_t = 32'h0020_0000;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_for_results();
			case (ph % 5)
				0: begin
					short_w = SHORT_WINDOW_RST;
					long_w  = LONG_WINDOW_RST;
					step    = 2_000_000;
				end
				1: begin
					short_w = $urandom_range(500, 5000);
					long_w  = short_w + $urandom_range(0, 20000);
					step    = 200;
				end
				2: begin
					short_w = '0;
					long_w  = 32'hFFFF_FFFF;
					step    = 1000;
				end
				3: begin
					short_w = $urandom;
					long_w  = $urandom;
					step    = $urandom_range(1, 1 << 24);
				end
				default: begin
					short_w = $urandom_range(0, 3000);
					long_w  = $urandom_range(0, 3000);
					step    = 100;
				end
			endcase
			write_register(CFG_SHORT_WINDOW, short_w);
			write_register(CFG_LONG_WINDOW, long_w);
			window_settings++;
			sender_idle   = (ph % 3 != 1);
			receiver_idle = (ph % 4 != 2);
			if (ph % 2 == 1)
				now_t = $urandom;

			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				// hold off mid-phase until the block has drained
				if (n == PHASE_SAMPLES / 2)
					wait_for_results();
				r = $urandom_range(0, 99);
				if (r < 85) begin
					now_t = now_t + $urandom_range(0, step);
					send_sample(now_t, $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
				end else if (r < 93) begin
					now_t = now_t - $urandom_range(0, step * 4);
					send_sample(now_t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					now_t = $urandom;
					send_sample(now_t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
		end

		wait_for_results();
		repeat (LOG_DEPTH + 20) @(posedge clk);

		$display("covered %0d samples under %0d window settings, %0d log entries written",
			samples_sent, window_settings, board.entries_written);
		$display("compared %0d result sets, %0d field mismatches",
			board.checked, board.errors);
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
